### design/mi3_pkg.sv
package mi3_pkg;

    // operand indexes of the nine adjugate entries (transposed cofactors), row-major: c = a[p0]*a[p1] - a[p2]*a[p3]
    localparam int unsigned COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // cofactors that multiply the first row in the determinant expansion
    localparam int unsigned DET_COF [3] = '{0, 3, 6};

    // per-lane flags that travel with the quotient
    typedef struct packed {
        logic neg;
        logic ovf;
    } mi3_lane_t;

    // per-item control that travels with the divider
    typedef struct packed {
        logic valid;
        logic singular;
        logic det_sat;
    } mi3_ctl_t;

endpackage

### design/mi3_front.sv
module mi3_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [WORD_BITS-1:0]    a_in [9],
    output logic                           out_valid,
    output logic signed [3*WORD_BITS+1:0]  det_out,
    output logic signed [2*WORD_BITS:0]    cof_out [9]
);
    import mi3_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int PPW  = 2 * W + 2;
    localparam int DETW = 3 * W + 2;

    logic [3:0] vld_reg;

    logic signed [PW-1:0]   p_reg [18];
    logic signed [PW-1:0]   p_next [18];
    logic signed [W-1:0]    a1_reg [3];
    logic signed [W-1:0]    a2_reg [3];
    logic signed [CW-1:0]   c2_reg [9];
    logic signed [CW-1:0]   c2_next [9];
    logic signed [CW-1:0]   c3_reg [9];
    logic signed [CW-1:0]   c4_reg [9];
    logic signed [PPW-1:0]  pl_reg [3];
    logic signed [PPW-1:0]  pl_next [3];
    logic signed [PPW-1:0]  ph_reg [3];
    logic signed [PPW-1:0]  ph_next [3];
    logic signed [DETW-1:0] det_reg;
    logic signed [DETW-1:0] det_next;

    // stage 1: pair products
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p_next[2*k]   = PW'(a_in[COF_IDX[k][0]]) * PW'(a_in[COF_IDX[k][1]]);
            p_next[2*k+1] = PW'(a_in[COF_IDX[k][2]]) * PW'(a_in[COF_IDX[k][3]]);
        end
    end

    // stage 2: cofactors
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            c2_next[k] = CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
        end
    end

    // stage 3: first-row terms as low and high partial products
    always_comb begin
        logic [W-1:0]        lo;
        logic signed [W:0]   hi;
        for (int j = 0; j < 3; j++) begin
            lo = c2_reg[DET_COF[j]][W-1:0];
            hi = c2_reg[DET_COF[j]][CW-1:W];
            pl_next[j] = PPW'($signed({1'b0, lo})) * PPW'(a2_reg[j]);
            ph_next[j] = PPW'(hi) * PPW'(a2_reg[j]);
        end
    end

    // stage 4: determinant
    always_comb begin
        det_next = '0;
        for (int j = 0; j < 3; j++) begin
            det_next = det_next + (DETW'(ph_reg[j]) <<< W) + DETW'(pl_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= p_next;
            a1_reg  <= a_in[0:2];
            a2_reg  <= a1_reg;
            c2_reg  <= c2_next;
            c3_reg  <= c2_reg;
            c4_reg  <= c3_reg;
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            det_reg <= det_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign det_out   = det_reg;
    assign cof_out   = c4_reg;

endmodule

### design/mi3_div_step.sv
module mi3_div_step #(
    parameter int WORD_BITS = 32,
    parameter int REM_BITS  = 146,
    parameter int MAG_BITS  = 98,
    parameter int BIT       = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  mi3_pkg::mi3_ctl_t           ctl_in,
    input  mi3_pkg::mi3_lane_t          flg_in [9],
    input  logic [MAG_BITS-1:0]         mag_in,
    input  logic [WORD_BITS-1:0]        detw_in,
    input  logic [REM_BITS-1:0]         rem_in [9],
    input  logic [WORD_BITS-1:0]        quo_in [9],
    output mi3_pkg::mi3_ctl_t           ctl_out,
    output mi3_pkg::mi3_lane_t          flg_out [9],
    output logic [MAG_BITS-1:0]         mag_out,
    output logic [WORD_BITS-1:0]        detw_out,
    output logic [REM_BITS-1:0]         rem_out [9],
    output logic [WORD_BITS-1:0]        quo_out [9]
);
    import mi3_pkg::*;

    mi3_ctl_t             ctl_reg;
    mi3_lane_t            flg_reg [9];
    logic [MAG_BITS-1:0]  mag_reg;
    logic [WORD_BITS-1:0] detw_reg;
    logic [REM_BITS-1:0]  rem_reg [9];
    logic [REM_BITS-1:0]  rem_next [9];
    logic [WORD_BITS-1:0] quo_reg [9];
    logic [WORD_BITS-1:0] quo_next [9];
    logic [REM_BITS-1:0]  trial;

    // one restoring quotient bit per lane
    always_comb begin
        trial = REM_BITS'(mag_in) << BIT;
        for (int k = 0; k < 9; k++) begin
            rem_next[k] = rem_in[k];
            quo_next[k] = quo_in[k];
            if (rem_in[k] >= trial) begin
                rem_next[k]      = rem_in[k] - trial;
                quo_next[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flg_reg  <= flg_in;
            mag_reg  <= mag_in;
            detw_reg <= detw_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign flg_out  = flg_reg;
    assign mag_out  = mag_reg;
    assign detw_out = detw_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;

endmodule

### design/matrix3x3_inverse.sv
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default)
//
// input channel: s_valid/s_ready, one matrix per transaction on s_in_r1c1..s_in_r3c3
// result channel: m_valid/m_ready, the inverse on m_out_*, the determinant on
//   m_det_value, m_singular when the determinant is exactly zero (identity
//   returned), m_saturated when any word was clamped
//
// path from input transaction to m_valid: registered stages of products, cofactors,
//   first-row terms and determinant, one of magnitude and range check, one per
//   quotient bit in the divider pipeline, then one output register
// throughput: one matrix per cycle while m_ready does not stall, set by the fully
//   pipelined divider, one stage per quotient bit for all nine lanes
//
// reset clears every valid bit; payload registers are left as they are
// when the receiver stalls the whole pipeline holds: s_ready drops together
//   with the stalled result, nothing is lost or repeated
module matrix3x3_inverse #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [WORD_BITS-1:0] s_in_r1c1,
    input  logic signed [WORD_BITS-1:0] s_in_r1c2,
    input  logic signed [WORD_BITS-1:0] s_in_r1c3,
    input  logic signed [WORD_BITS-1:0] s_in_r2c1,
    input  logic signed [WORD_BITS-1:0] s_in_r2c2,
    input  logic signed [WORD_BITS-1:0] s_in_r2c3,
    input  logic signed [WORD_BITS-1:0] s_in_r3c1,
    input  logic signed [WORD_BITS-1:0] s_in_r3c2,
    input  logic signed [WORD_BITS-1:0] s_in_r3c3,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_BITS-1:0] m_out_r1c1,
    output logic signed [WORD_BITS-1:0] m_out_r1c2,
    output logic signed [WORD_BITS-1:0] m_out_r1c3,
    output logic signed [WORD_BITS-1:0] m_out_r2c1,
    output logic signed [WORD_BITS-1:0] m_out_r2c2,
    output logic signed [WORD_BITS-1:0] m_out_r2c3,
    output logic signed [WORD_BITS-1:0] m_out_r3c1,
    output logic signed [WORD_BITS-1:0] m_out_r3c2,
    output logic signed [WORD_BITS-1:0] m_out_r3c3,
    output logic signed [WORD_BITS-1:0] m_det_value,
    output logic                        m_singular,
    output logic                        m_saturated
);
    import mi3_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int CW   = 2 * W + 1;
    localparam int DETW = 3 * W + 2;
    localparam int RW   = 4 * W + 2 + 2 * FRAC_BITS;

    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic         ONE_SAT = (FRAC_BITS >= WORD_BITS - 1);
    localparam logic [W-1:0] DIAG    = ONE_SAT ? LIM_POS : (W'(1) << FRAC_BITS);

    // the whole pipeline moves when the output register is free or being taken
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // products, cofactors, determinant
    logic signed [W-1:0]    a_in [9];
    logic                   fr_valid;
    logic signed [DETW-1:0] fr_det;
    logic signed [CW-1:0]   fr_cof [9];

    assign a_in = '{s_in_r1c1, s_in_r1c2, s_in_r1c3,
                    s_in_r2c1, s_in_r2c2, s_in_r2c3,
                    s_in_r3c1, s_in_r3c2, s_in_r3c3};

    mi3_front #(
        .WORD_BITS (W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .a_in      (a_in),
        .out_valid (fr_valid),
        .det_out   (fr_det),
        .cof_out   (fr_cof)
    );

    // magnitudes, signs, quotient range check, determinant word
    mi3_ctl_t         pre_ctl_reg;
    mi3_ctl_t         pre_ctl_next;
    mi3_lane_t        pre_flg_reg [9];
    mi3_lane_t        pre_flg_next [9];
    logic [DETW-1:0]  pre_mag_reg;
    logic [DETW-1:0]  pre_mag_next;
    logic [W-1:0]     pre_detw_reg;
    logic [W-1:0]     pre_detw_next;
    logic [RW-1:0]    pre_rem_reg [9];
    logic [RW-1:0]    pre_rem_next [9];

    always_comb begin
        logic [CW-1:0]   cmag;
        logic [DETW-1:0] dshift;
        logic [W-1:0]    dlim;
        logic [W-1:0]    dq;
        logic            dsat;
        logic            dneg;

        dneg         = fr_det[DETW-1];
        pre_mag_next = dneg ? DETW'(-fr_det) : DETW'(fr_det);

        for (int k = 0; k < 9; k++) begin
            cmag = fr_cof[k][CW-1] ? CW'(-fr_cof[k]) : CW'(fr_cof[k]);
            pre_rem_next[k]     = RW'(cmag) << (2 * FRAC_BITS);
            pre_flg_next[k].neg = fr_cof[k][CW-1] ^ dneg;
            // quotient would need more than W bits
            pre_flg_next[k].ovf = pre_rem_next[k] >= (RW'(pre_mag_next) << W);
        end

        // determinant truncated to FRAC_BITS fraction bits, then clamped
        dshift = pre_mag_next >> (2 * FRAC_BITS);
        dlim   = dneg ? LIM_NEG : LIM_POS;
        dsat   = dshift > DETW'(dlim);
        dq     = dsat ? dlim : dshift[W-1:0];
        pre_detw_next = dneg ? (~dq + W'(1)) : dq;

        pre_ctl_next.valid    = fr_valid;
        pre_ctl_next.singular = (fr_det == '0);
        pre_ctl_next.det_sat  = dsat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_ctl_reg <= '0;
        end else if (en) begin
            pre_ctl_reg <= pre_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_flg_reg  <= pre_flg_next;
            pre_mag_reg  <= pre_mag_next;
            pre_detw_reg <= pre_detw_next;
            pre_rem_reg  <= pre_rem_next;
        end
    end

    // divider pipeline: stage s resolves quotient bit W-1-s for all nine lanes
    mi3_ctl_t        dv_ctl  [W+1];
    mi3_lane_t       dv_flg  [W+1][9];
    logic [DETW-1:0] dv_mag  [W+1];
    logic [W-1:0]    dv_detw [W+1];
    logic [RW-1:0]   dv_rem  [W+1][9];
    logic [W-1:0]    dv_quo  [W+1][9];

    assign dv_ctl[0]  = pre_ctl_reg;
    assign dv_flg[0]  = pre_flg_reg;
    assign dv_mag[0]  = pre_mag_reg;
    assign dv_detw[0] = pre_detw_reg;
    assign dv_rem[0]  = pre_rem_reg;
    assign dv_quo[0]  = '{default: '0};

    for (genvar s = 0; s < W; s++) begin : g_div
        mi3_div_step #(
            .WORD_BITS (W),
            .REM_BITS  (RW),
            .MAG_BITS  (DETW),
            .BIT       (W - 1 - s)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctl_in   (dv_ctl[s]),
            .flg_in   (dv_flg[s]),
            .mag_in   (dv_mag[s]),
            .detw_in  (dv_detw[s]),
            .rem_in   (dv_rem[s]),
            .quo_in   (dv_quo[s]),
            .ctl_out  (dv_ctl[s+1]),
            .flg_out  (dv_flg[s+1]),
            .mag_out  (dv_mag[s+1]),
            .detw_out (dv_detw[s+1]),
            .rem_out  (dv_rem[s+1]),
            .quo_out  (dv_quo[s+1])
        );
    end

    // sign, clamp, singular substitution into the output register
    logic [W-1:0] out_reg [9];
    logic [W-1:0] out_next [9];
    logic [W-1:0] det_reg;
    logic [W-1:0] det_next;
    logic         sing_reg;
    logic         sat_reg;
    logic         sat_next;

    always_comb begin
        logic [W-1:0] lim;
        logic [W-1:0] q;
        logic         lsat;
        mi3_ctl_t     ctl;

        ctl      = dv_ctl[W];
        sat_next = ctl.det_sat;
        for (int k = 0; k < 9; k++) begin
            lim  = dv_flg[W][k].neg ? LIM_NEG : LIM_POS;
            lsat = dv_flg[W][k].ovf || (dv_quo[W][k] > lim);
            q    = lsat ? lim : dv_quo[W][k];
            out_next[k] = dv_flg[W][k].neg ? (~q + W'(1)) : q;
            sat_next    = sat_next | lsat;
        end
        det_next = dv_detw[W];

        // singular matrix: identity, zero determinant
        if (ctl.singular) begin
            for (int k = 0; k < 9; k++) begin
                out_next[k] = (k % 4 == 0) ? DIAG : '0;
            end
            det_next = '0;
            sat_next = ONE_SAT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_ctl[W].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg  <= out_next;
            det_reg  <= det_next;
            sing_reg <= dv_ctl[W].singular;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_r1c1  = out_reg[0];
    assign m_out_r1c2  = out_reg[1];
    assign m_out_r1c3  = out_reg[2];
    assign m_out_r2c1  = out_reg[3];
    assign m_out_r2c2  = out_reg[4];
    assign m_out_r2c3  = out_reg[5];
    assign m_out_r3c1  = out_reg[6];
    assign m_out_r3c2  = out_reg[7];
    assign m_out_r3c3  = out_reg[8];
    assign m_det_value = det_reg;
    assign m_singular  = sing_reg;
    assign m_saturated = sat_reg;

endmodule

### bench/testbench.sv
module testbench;
    import mi3_pkg::*;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
    localparam logic signed [31:0] MAX_Q = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // one matrix inverse result, as seen on the result channel
    typedef struct {
        word_t inv [9];
        word_t det;
        logic  singular;
        logic  saturated;
    } inverse_t;

    // directed stimulus row; known is set where the result is typed in
    typedef struct {
        word_t    mat [9];
        logic     known;
        inverse_t res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    word_t s_in [9];
    logic m_valid;
    logic m_ready = 1'b0;
    word_t m_out [9];
    word_t m_det_value;
    logic m_singular;
    logic m_saturated;

    inverse_t expected_q [$];
    int error_count = 0;
    int cycle_count = 0;

    initial begin
        for (int i = 0; i < 9; i++) s_in[i] = '0;
    end

    always #2 aclk = ~aclk;

    matrix3x3_inverse #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_r1c1(s_in[0]), .s_in_r1c2(s_in[1]), .s_in_r1c3(s_in[2]),
        .s_in_r2c1(s_in[3]), .s_in_r2c2(s_in[4]), .s_in_r2c3(s_in[5]),
        .s_in_r3c1(s_in[6]), .s_in_r3c2(s_in[7]), .s_in_r3c3(s_in[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_r1c1(m_out[0]), .m_out_r1c2(m_out[1]), .m_out_r1c3(m_out[2]),
        .m_out_r2c1(m_out[3]), .m_out_r2c2(m_out[4]), .m_out_r2c3(m_out[5]),
        .m_out_r3c1(m_out[6]), .m_out_r3c2(m_out[7]), .m_out_r3c3(m_out[8]),
        .m_det_value(m_det_value), .m_singular(m_singular), .m_saturated(m_saturated)
    );

    // clamp a signed value to the word range, flag any clamping
    function automatic word_t clamp_word(logic signed [255:0] v, ref logic sat);
        if (v > 256'sd2147483647) begin
            sat = 1'b1;
            return MAX_Q;
        end
        if (v < -256'sd2147483648) begin
            sat = 1'b1;
            return MIN_Q;
        end
        return word_t'(v);
    endfunction

    // exact adjugate inverse: cofactor * 2^32 / det, truncated toward zero
    function automatic inverse_t invert_matrix(word_t m [9]);
        inverse_t r;
        logic signed [255:0] a [9];
        logic signed [255:0] det, cof, num, mag, quo;
        logic sat;
        sat = 1'b0;
        for (int i = 0; i < 9; i++) a[i] = m[i];
        det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
            - a[0]*a[5]*a[7] - a[1]*a[3]*a[8] - a[2]*a[4]*a[6];
        if (det == 0) begin
            for (int i = 0; i < 9; i++) r.inv[i] = '0;
            r.inv[0] = ONE_Q;
            r.inv[4] = ONE_Q;
            r.inv[8] = ONE_Q;
            r.det = '0;
            r.singular = 1'b1;
            r.saturated = 1'b0;
            return r;
        end
        mag = (det < 0) ? -det : det;
        for (int i = 0; i < 9; i++) begin
            cof = a[COF_IDX[i][0]] * a[COF_IDX[i][1]] - a[COF_IDX[i][2]] * a[COF_IDX[i][3]];
            num = ((cof < 0) ? -cof : cof) <<< (2 * FRAC_BITS);
            quo = num / mag;
            if ((cof < 0) != (det < 0)) quo = -quo;
            r.inv[i] = clamp_word(quo, sat);
        end
        // determinant scaled back to Q16.16, toward zero
        quo = mag >>> (2 * FRAC_BITS);
        if (det < 0) quo = -quo;
        r.det = clamp_word(quo, sat);
        r.singular = 1'b0;
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // random element: full range, small values, extremes
    function automatic word_t random_element();
        case ($urandom_range(0, 5))
            0: return word_t'($urandom);
            1: return word_t'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            2: return $urandom_range(0, 1) ? MAX_Q : MIN_Q;
            3: return word_t'($signed($urandom_range(0, 400)) - 200);
            default: return word_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    // send one matrix transaction, with a random gap first
    task automatic send_matrix(word_t m [9]);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 9; i++) s_in[i] <= m[i];
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(invert_matrix(m));
    endtask

    // receiver stall: fresh wait count per result
    initial begin
        int wait_cycles;
        @(posedge aresetn);
        forever begin
            wait_cycles = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // result checker, compares each transaction with the oldest expectation
    always @(posedge aclk) begin
        inverse_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result transaction at cycle %0d", cycle_count);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_out[i] !== want.inv[i])
                        report_mismatch($sformatf("out[%0d]", i), m_out[i], want.inv[i]);
                if (m_det_value !== want.det)
                    report_mismatch("det_value", m_det_value, want.det);
                if (m_singular !== want.singular)
                    report_mismatch("singular", word_t'(m_singular), word_t'(want.singular));
                if (m_saturated !== want.saturated)
                    report_mismatch("saturated", word_t'(m_saturated), word_t'(want.saturated));
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout at cycle %0d", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // directed table: identity, zero, extremes, sign cases, saturation
    function automatic stim_row_t make_row(word_t m [9]);
        stim_row_t row;
        row.mat = m;
        row.known = 1'b0;
        return row;
    endfunction

    initial begin
        stim_row_t table_rows [$];
        stim_row_t row;
        word_t m [9];
        inverse_t got;

        // identity: inverse is identity, det 1.0
        m = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
        row = make_row(m);
        row.known = 1'b1;
        row.res.inv = m;
        row.res.det = ONE_Q;
        row.res.singular = 1'b0;
        row.res.saturated = 1'b0;
        table_rows.push_back(row);
        // all zero: singular, identity returned
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        row = make_row(m);
        row.known = 1'b1;
        row.res.inv = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
        row.res.det = '0;
        row.res.singular = 1'b1;
        row.res.saturated = 1'b0;
        table_rows.push_back(row);
        // all max: singular
        m = '{MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q};
        row = make_row(m);
        row.known = 1'b1;
        row.res.inv = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
        row.res.det = '0;
        row.res.singular = 1'b1;
        row.res.saturated = 1'b0;
        table_rows.push_back(row);
        // predictor-checked rows
        table_rows.push_back(make_row('{MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                                        MIN_Q, MIN_Q, MIN_Q}));
        table_rows.push_back(make_row('{MIN_Q, 0, 0, 0, MIN_Q, 0, 0, 0, MIN_Q}));
        table_rows.push_back(make_row('{MAX_Q, 0, 0, 0, MAX_Q, 0, 0, 0, MAX_Q}));
        table_rows.push_back(make_row('{MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q,
                                        MAX_Q, MAX_Q, MIN_Q}));
        table_rows.push_back(make_row('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
        table_rows.push_back(make_row('{-1, 0, 0, 0, 1, 0, 0, 0, 1}));
        table_rows.push_back(make_row('{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}));
        table_rows.push_back(make_row('{2 * ONE_Q, 0, 0, 0, 3 * ONE_Q, 0, 0, 0, 7 * ONE_Q}));
        table_rows.push_back(make_row('{0, ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q}));
        table_rows.push_back(make_row('{ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0, ONE_Q, 4 * ONE_Q,
                                        5 * ONE_Q, 6 * ONE_Q, 0}));
        table_rows.push_back(make_row('{-1, -1, -1, -1, -1, -1, -1, -1, -2}));
        table_rows.push_back(make_row('{MAX_Q, MAX_Q, 0, MAX_Q, MIN_Q, 0, 0, 0, MAX_Q}));
        table_rows.push_back(make_row('{32'sh5555_5555, 32'shAAAA_AAAA, 1, 7, -3,
                                        32'sh1234_5678, 0, ONE_Q, -ONE_Q}));
        table_rows.push_back(make_row('{ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q + 1, 0,
                                        0, 0, ONE_Q}));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[i]) begin
            if (table_rows[i].known) begin
                got = invert_matrix(table_rows[i].mat);
                if (got.inv != table_rows[i].res.inv || got.det !== table_rows[i].res.det
                        || got.singular !== table_rows[i].res.singular
                        || got.saturated !== table_rows[i].res.saturated) begin
                    $display("table row %0d disagrees with predictor", i);
                    error_count++;
                end
            end
            send_matrix(table_rows[i].mat);
        end

        // random part; some rows rank deficient to hit the singular path
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            for (int i = 0; i < 9; i++) m[i] = random_element();
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 3; i++) m[6 + i] = m[i];
            send_matrix(m);
        end
        s_valid <= 1'b0;

        wait (expected_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### files.f
design/mi3_pkg.sv
design/mi3_front.sv
design/mi3_div_step.sv
design/matrix3x3_inverse.sv
bench/testbench.sv
